// ===== rtl/biquad_highpass_audio_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the biquad high-pass filter
// ----------------------------------------------------------------------------
`ifndef BIQUAD_HIGHPASS_AUDIO_FILTER_MACROS_SVH
`define BIQUAD_HIGHPASS_AUDIO_FILTER_MACROS_SVH

// Checked on every rising edge outside reset.
`define BQHP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("bqhp: assertion failed");

// Checked on every rising edge, reset included.
`define BQHP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("bqhp: assertion failed");

`endif

// ===== rtl/bqhp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqhp_pkg
// Widths, reset coefficients, register indexes and shared types of the
// biquad high-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bqhp_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int COEF_FRAC_BITS  = 22;
   localparam int STATE_FRAC_BITS = 8;

   localparam int COEF_BITS    = COEF_FRAC_BITS + 2;
   localparam int STATE_BITS   = SAMPLE_BITS + STATE_FRAC_BITS;
   localparam int FF_PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int FB_PROD_BITS = COEF_BITS + STATE_BITS;
   localparam int FF_SUM_BITS  = FF_PROD_BITS + 2;
   localparam int ACC_BASE     = (FF_SUM_BITS + STATE_FRAC_BITS > FB_PROD_BITS + 1) ?
                                 (FF_SUM_BITS + STATE_FRAC_BITS) : (FB_PROD_BITS + 1);
   localparam int ACC_BITS     = ACC_BASE + 2;
   localparam int Y_WIDE_BITS  = ACC_BITS - COEF_FRAC_BITS;

   // half an LSB of the state, in accumulator scale
   localparam logic [ACC_BITS-1:0] ACC_HALF =
      {{(ACC_BITS - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
   // half an LSB of the sample, in state scale (zero with no fraction bits)
   localparam logic [STATE_BITS:0] STATE_HALF =
      (STATE_BITS + 1)'((64'd1 << STATE_FRAC_BITS) >> 1);

   localparam logic [COEF_BITS-1:0] RESET_A0 = COEF_BITS'(4129219);
   localparam logic [COEF_BITS-1:0] RESET_A1 = COEF_BITS'(-8258438);
   localparam logic [COEF_BITS-1:0] RESET_A2 = COEF_BITS'(4129219);
   localparam logic [COEF_BITS-1:0] RESET_B1 = COEF_BITS'(-8257428);
   localparam logic [COEF_BITS-1:0] RESET_B2 = COEF_BITS'(4065144);

   localparam int NUM_REGS      = 6;
   localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_BITS = REG_IDX_BITS + 2;

   localparam logic [REG_IDX_BITS-1:0] REG_FILTER_ENABLE  = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_IN_NOW    = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_IN_PREV   = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_IN_OLDER  = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_OUT_PREV  = REG_IDX_BITS'(4);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_OUT_OLDER = REG_IDX_BITS'(5);

   typedef struct packed {
      logic                        filter_enable;
      logic signed [COEF_BITS-1:0] coef_in_now;
      logic signed [COEF_BITS-1:0] coef_in_prev;
      logic signed [COEF_BITS-1:0] coef_in_older;
      logic signed [COEF_BITS-1:0] coef_out_prev;
      logic signed [COEF_BITS-1:0] coef_out_older;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] input_delay_one;
      logic signed [SAMPLE_BITS-1:0] input_delay_two;
      logic signed [STATE_BITS-1:0]  output_delay_one;
      logic signed [STATE_BITS-1:0]  output_delay_two;
   } hist_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
      logic signed [STATE_BITS-1:0]  state_out;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/biquad_highpass_audio_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_highpass_audio_filter: second-order IIR high-pass, direct form I
// A sample passes the input register, then the result register.
// Throughput 1 sample per cycle unless the receiver stalls; feedback runs through the history register.
// Reset clears delay state and handshakes and loads the DC-blocking set.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_highpass_audio_filter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [bqhp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [bqhp_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                                       rsp_clipped,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [bqhp_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   output logic      [31:0]                           csr_prdata,
   output logic                                       csr_pready
);

   bqhp_pkg::cfg_type    cfg;
   bqhp_pkg::result_type result;

   logic                                  in_valid_ff, in_valid_in;
   logic signed [bqhp_pkg::SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                                  out_valid_ff, out_valid_in;
   logic signed [bqhp_pkg::SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                                  out_clipped_ff, out_clipped_in;
   bqhp_pkg::hist_type                    hist_ff, hist_in;
   logic                                  advance;
   logic                                  req_xfer;

   bqhp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bqhp_arith u_arith (
      .sample_in (in_sample_ff),
      .hist      (hist_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // move the held sample into the result register when it is free or being emptied
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_xfer  = req_valid & req_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_clipped    = out_clipped_ff;

   always_comb begin
      in_valid_in    = req_xfer | (in_valid_ff & ~advance);
      in_sample_in   = req_xfer ? req_sample_in : in_sample_ff;
      out_valid_in   = advance | (out_valid_ff & ~rsp_ready);
      out_sample_in  = advance ? result.sample_out : out_sample_ff;
      out_clipped_in = advance ? result.clipped : out_clipped_ff;
      hist_in        = hist_ff;
      // bypass leaves the delay line untouched
      if (advance & cfg.filter_enable) begin
         hist_in.input_delay_two  = hist_ff.input_delay_one;
         hist_in.input_delay_one  = in_sample_ff;
         hist_in.output_delay_two = hist_ff.output_delay_one;
         hist_in.output_delay_one = result.state_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff   <= in_sample_in;
      out_sample_ff  <= out_sample_in;
      out_clipped_ff <= out_clipped_in;
   end

endmodule

`default_nettype wire

// ===== rtl/bqhp_csr.sv =====
// ----------------------------------------------------------------------------
// bqhp_csr
// APB-style register file holding the bypass switch and the five
// filter coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module bqhp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bqhp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready,
   output bqhp_pkg::cfg_type                       cfg
);

   bqhp_pkg::cfg_type                    cfg_ff;
   bqhp_pkg::cfg_type                    cfg_in;
   logic [bqhp_pkg::REG_IDX_BITS-1:0]    reg_idx;
   logic [bqhp_pkg::COEF_BITS-1:0]       wr_coef;
   logic                                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[bqhp_pkg::CSR_ADDR_BITS-1:2];
   assign wr_coef    = csr_pwdata[bqhp_pkg::COEF_BITS-1:0];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            bqhp_pkg::REG_FILTER_ENABLE:  cfg_in.filter_enable  = csr_pwdata[0];
            bqhp_pkg::REG_COEF_IN_NOW:    cfg_in.coef_in_now    = wr_coef;
            bqhp_pkg::REG_COEF_IN_PREV:   cfg_in.coef_in_prev   = wr_coef;
            bqhp_pkg::REG_COEF_IN_OLDER:  cfg_in.coef_in_older  = wr_coef;
            bqhp_pkg::REG_COEF_OUT_PREV:  cfg_in.coef_out_prev  = wr_coef;
            bqhp_pkg::REG_COEF_OUT_OLDER: cfg_in.coef_out_older = wr_coef;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_enable  <= 1'b1;
         cfg_ff.coef_in_now    <= bqhp_pkg::RESET_A0;
         cfg_ff.coef_in_prev   <= bqhp_pkg::RESET_A1;
         cfg_ff.coef_in_older  <= bqhp_pkg::RESET_A2;
         cfg_ff.coef_out_prev  <= bqhp_pkg::RESET_B1;
         cfg_ff.coef_out_older <= bqhp_pkg::RESET_B2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // coefficients read back sign-extended
   always_comb begin
      case (reg_idx)
         bqhp_pkg::REG_FILTER_ENABLE:  csr_prdata = {31'd0, cfg_ff.filter_enable};
         bqhp_pkg::REG_COEF_IN_NOW:    csr_prdata = 32'(cfg_ff.coef_in_now);
         bqhp_pkg::REG_COEF_IN_PREV:   csr_prdata = 32'(cfg_ff.coef_in_prev);
         bqhp_pkg::REG_COEF_IN_OLDER:  csr_prdata = 32'(cfg_ff.coef_in_older);
         bqhp_pkg::REG_COEF_OUT_PREV:  csr_prdata = 32'(cfg_ff.coef_out_prev);
         bqhp_pkg::REG_COEF_OUT_OLDER: csr_prdata = 32'(cfg_ff.coef_out_older);
         default:                      csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/bqhp_arith.sv =====
// ----------------------------------------------------------------------------
// bqhp_arith
// Direct form I biquad arithmetic: five products, sum, rounding and
// saturation of the state and of the output sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bqhp_arith (
   input  wire logic signed [bqhp_pkg::SAMPLE_BITS-1:0] sample_in,
   input  wire bqhp_pkg::hist_type                      hist,
   input  wire bqhp_pkg::cfg_type                       cfg,
   output bqhp_pkg::result_type                         result
);

   localparam int SB = bqhp_pkg::SAMPLE_BITS;
   localparam int ST = bqhp_pkg::STATE_BITS;
   localparam int YW = bqhp_pkg::Y_WIDE_BITS;
   localparam int AB = bqhp_pkg::ACC_BITS;

   logic signed [bqhp_pkg::FF_PROD_BITS-1:0] ff_p0, ff_p1, ff_p2;
   logic signed [bqhp_pkg::FB_PROD_BITS-1:0] fb_p1, fb_p2;
   logic signed [bqhp_pkg::FF_SUM_BITS-1:0]  ff_sum;
   logic signed [AB-1:0]                     acc;
   logic        [AB-1:0]                     acc_rnd;
   logic        [YW-1:0]                     y_wide;
   logic        [YW-ST:0]                    y_hi;
   logic                                     y_ok;
   logic        [ST-1:0]                     y_sat;
   logic        [ST:0]                       s_sum;
   logic        [SB:0]                       s_wide;
   logic                                     s_ok;
   logic        [SB-1:0]                     s_sat;

   assign ff_p0 = cfg.coef_in_now   * sample_in;
   assign ff_p1 = cfg.coef_in_prev  * hist.input_delay_one;
   assign ff_p2 = cfg.coef_in_older * hist.input_delay_two;
   assign fb_p1 = cfg.coef_out_prev  * hist.output_delay_one;
   assign fb_p2 = cfg.coef_out_older * hist.output_delay_two;

   assign ff_sum = bqhp_pkg::FF_SUM_BITS'(ff_p0) + bqhp_pkg::FF_SUM_BITS'(ff_p1)
                 + bqhp_pkg::FF_SUM_BITS'(ff_p2);
   // align feed-forward terms to the feedback fraction
   assign acc = (AB'(ff_sum) <<< bqhp_pkg::STATE_FRAC_BITS) - AB'(fb_p1) - AB'(fb_p2);

   // round half up, floor by dropping the low bits
   assign acc_rnd = acc + bqhp_pkg::ACC_HALF;
   assign y_wide  = acc_rnd[AB-1:bqhp_pkg::COEF_FRAC_BITS];
   assign y_hi    = y_wide[YW-1:ST-1];
   assign y_ok    = (&y_hi) | ~(|y_hi);
   assign y_sat   = y_ok ? y_wide[ST-1:0] : {y_wide[YW-1], {(ST-1){~y_wide[YW-1]}}};

   assign s_sum  = {y_sat[ST-1], y_sat} + bqhp_pkg::STATE_HALF;
   assign s_wide = s_sum[ST:bqhp_pkg::STATE_FRAC_BITS];
   assign s_ok   = s_wide[SB] == s_wide[SB-1];
   assign s_sat  = s_ok ? s_wide[SB-1:0] : {s_wide[SB], {(SB-1){~s_wide[SB]}}};

   always_comb begin
      result.state_out = y_sat;
      if (cfg.filter_enable) begin
         result.sample_out = s_sat;
         result.clipped    = ~y_ok | ~s_ok;
      end else begin
         result.sample_out = sample_in;
         result.clipped    = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bqhp_checker.sv =====
// ----------------------------------------------------------------------------
// bqhp_checker
// Port-level checks of the biquad high-pass filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "biquad_highpass_audio_filter_macros.svh"

module bqhp_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [bqhp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input wire logic                                  rsp_clipped
);

   localparam logic [bqhp_pkg::SAMPLE_BITS-1:0] SAT_HI =
      {1'b0, {(bqhp_pkg::SAMPLE_BITS - 1){1'b1}}};
   localparam logic [bqhp_pkg::SAMPLE_BITS-1:0] SAT_LO =
      {1'b1, {(bqhp_pkg::SAMPLE_BITS - 1){1'b0}}};

   logic rsp_stall;
   logic rsp_full_scale;

   assign rsp_stall      = rsp_valid & ~rsp_ready;
   assign rsp_full_scale = (rsp_sample_out == SAT_HI) | (rsp_sample_out == SAT_LO);

   // a stalled result keeps its transfer pending
   `BQHP_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable({rsp_sample_out, rsp_clipped}))

   `BQHP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

   // input only backs up behind a stalled output
   `BQHP_ASSERT(a_ready_stall, !req_ready |-> rsp_stall)

   // a clipped sample sits at full scale
   `BQHP_ASSERT(a_clip_full_scale, rsp_valid && rsp_clipped |-> rsp_full_scale)

endmodule

bind biquad_highpass_audio_filter bqhp_checker u_bqhp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the biquad high-pass audio filter
// Streams signed samples through the block under random sender bursts and
// receiver stalls, predicts every filtered sample and clip flag in fixed
// point, and reprograms the coefficients over the APB port between phases.
// ----------------------------------------------------------------------------

module tb_top;
   import bqhp_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int PRINT_CAP    = 100;

   localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_A = REG_IDX_BITS'(NUM_REGS);
   localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_B = REG_IDX_BITS'(NUM_REGS + 1);

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam int COEF_ONE = 1 << COEF_FRAC_BITS;

   // --------------------------------------------------------------------
   // Fixed-point model of the filter and queue of filtered samples
   // --------------------------------------------------------------------
   class biquad_scoreboard;
      typedef struct packed {
         logic signed [SAMPLE_BITS-1:0] sample_out;
         logic                          clipped;
      } filtered_sample_type;

      cfg_type             cfg;
      hist_type            hist;
      filtered_sample_type filtered_samples[$];
      int                  mismatches;
      int                  results_seen;

      function new();
         cfg.filter_enable  = 1'b1;
         cfg.coef_in_now    = RESET_A0;
         cfg.coef_in_prev   = RESET_A1;
         cfg.coef_in_older  = RESET_A2;
         cfg.coef_out_prev  = RESET_B1;
         cfg.coef_out_older = RESET_B2;
         hist               = '0;
         mismatches         = 0;
         results_seen       = 0;
      endfunction

      task report(string msg);
         if (mismatches < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] data);
         case (idx)
            REG_FILTER_ENABLE:  cfg.filter_enable  = data[0];
            REG_COEF_IN_NOW:    cfg.coef_in_now    = data[COEF_BITS-1:0];
            REG_COEF_IN_PREV:   cfg.coef_in_prev   = data[COEF_BITS-1:0];
            REG_COEF_IN_OLDER:  cfg.coef_in_older  = data[COEF_BITS-1:0];
            REG_COEF_OUT_PREV:  cfg.coef_out_prev  = data[COEF_BITS-1:0];
            REG_COEF_OUT_OLDER: cfg.coef_out_older = data[COEF_BITS-1:0];
            default: ;  // unmapped index, dropped
         endcase
      endfunction

      task check_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] data);
         logic [COEF_BITS-1:0] want;
         want = '0;
         case (idx)
            REG_FILTER_ENABLE:  want = COEF_BITS'(cfg.filter_enable);
            REG_COEF_IN_NOW:    want = cfg.coef_in_now;
            REG_COEF_IN_PREV:   want = cfg.coef_in_prev;
            REG_COEF_IN_OLDER:  want = cfg.coef_in_older;
            REG_COEF_OUT_PREV:  want = cfg.coef_out_prev;
            REG_COEF_OUT_OLDER: want = cfg.coef_out_older;
            default: ;
         endcase
         if (idx == REG_FILTER_ENABLE) begin
            if (data[0] !== want[0])
               report($sformatf("reg %0d read %0h, want %0h", idx, data[0], want[0]));
         end else if (data[COEF_BITS-1:0] !== want) begin
            report($sformatf("reg %0d read %0h, want %0h", idx, data[COEF_BITS-1:0], want));
         end
      endtask

      function longint saturate(longint v, int bits, inout bit clip);
         longint hi, lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            clip = 1'b1;
            return hi;
         end
         if (v < lo) begin
            clip = 1'b1;
            return lo;
         end
         return v;
      endfunction

      // one accepted sample -> one expected output; history moves only when filtering
      function void filter_sample(logic signed [SAMPLE_BITS-1:0] x);
         filtered_sample_type res;
         longint ff, acc, y, s;
         bit clip;
         clip = 1'b0;
         if (!cfg.filter_enable) begin
            res.sample_out = x;
            res.clipped    = 1'b0;
         end else begin
            ff  = longint'($signed(cfg.coef_in_now))   * longint'(x)
                + longint'($signed(cfg.coef_in_prev))  * longint'($signed(hist.input_delay_one))
                + longint'($signed(cfg.coef_in_older)) * longint'($signed(hist.input_delay_two));
            acc = (ff <<< STATE_FRAC_BITS)
                - longint'($signed(cfg.coef_out_prev))  * longint'($signed(hist.output_delay_one))
                - longint'($signed(cfg.coef_out_older)) * longint'($signed(hist.output_delay_two));
            // round half up to the state grid, then to whole samples
            y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            y = saturate(y, STATE_BITS, clip);
            s = (y + ((longint'(1) <<< STATE_FRAC_BITS) >>> 1)) >>> STATE_FRAC_BITS;
            s = saturate(s, SAMPLE_BITS, clip);
            hist.input_delay_two  = hist.input_delay_one;
            hist.input_delay_one  = x;
            hist.output_delay_two = hist.output_delay_one;
            hist.output_delay_one = y[STATE_BITS-1:0];
            res.sample_out = s[SAMPLE_BITS-1:0];
            res.clipped    = clip;
         end
         filtered_samples.push_back(res);
      endfunction

      task check_result(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_clipped);
         filtered_sample_type want;
         results_seen++;
         if (filtered_samples.size() == 0) begin
            report($sformatf("output %0d: sample %0d with nothing pending",
                             results_seen, got_sample));
         end else begin
            want = filtered_samples.pop_front();
            if (got_sample !== want.sample_out)
               report($sformatf("output %0d: sample_out %0d, want %0d",
                                results_seen, got_sample, want.sample_out));
            if (got_clipped !== want.clipped)
               report($sformatf("output %0d: clipped %0b, want %0b",
                                results_seen, got_clipped, want.clipped));
         end
      endtask

      function int pending();
         return filtered_samples.size();
      endfunction
   endclass

   // --------------------------------------------------------------------
   // DUT hookup
   // --------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic signed [SAMPLE_BITS-1:0]   req_sample_in = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_out;
   logic                            rsp_clipped;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]        csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   biquad_highpass_audio_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   biquad_scoreboard sb;

   always #2 clock = ~clock;

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // input transfers are predicted before outputs are checked on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.filter_sample(req_sample_in);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_sample_out, rsp_clipped);
      end
   end

   // receiver backpressure: free-running, switching between randomly chosen modes
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_hold = 0;
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(0, 3);
         rx_mode_left = $urandom_range(32, 256);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (rx_mode_left % 4 == 0);
         default: begin
            // long stalls with short ready windows
            if (rx_hold == 0) begin
               rsp_ready <= !rsp_ready;
               rx_hold = rsp_ready ? $urandom_range(5, 24) : $urandom_range(1, 4);
            end else begin
               rx_hold--;
            end
         end
      endcase
   end

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------
   int  wave_mode = 0;
   int  walk_value = 0;
   int  square_left = 0;
   bit  square_high = 1'b0;

   function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
      case (wave_mode)
         0: return SAMPLE_BITS'($urandom);
         1: begin
            // slow random walk, mostly low-frequency content
            walk_value += int'($urandom_range(0, 1024)) - 512;
            if (walk_value > int'(SAMPLE_MAX)) walk_value = int'(SAMPLE_MAX);
            if (walk_value < int'(SAMPLE_MIN)) walk_value = int'(SAMPLE_MIN);
            return SAMPLE_BITS'(walk_value);
         end
         2: begin
            if (square_left == 0) begin
               square_high = !square_high;
               square_left = $urandom_range(1, 12);
            end
            square_left--;
            return square_high ? SAMPLE_MAX : SAMPLE_MIN;
         end
         3: return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
         default: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      endcase
   endfunction

   task send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task run_random(input int count);
      int sent, burst, gap, k;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0)
            wave_mode = $urandom_range(0, 4);
         burst = $urandom_range(1, 48);
         for (k = 0; k < burst && sent < count; k++) begin
            send_sample(next_sample());
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0)
            idle_sender(gap);
      end
   endtask

   // hold the sender until every filtered sample is back, then let the pipe settle
   task drain();
      idle_sender(1);
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task csr_read(input logic [REG_IDX_BITS-1:0] idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.check_register(idx, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task read_all_registers();
      csr_read(REG_FILTER_ENABLE);
      csr_read(REG_COEF_IN_NOW);
      csr_read(REG_COEF_IN_PREV);
      csr_read(REG_COEF_IN_OLDER);
      csr_read(REG_COEF_OUT_PREV);
      csr_read(REG_COEF_OUT_OLDER);
   endtask

   // upper pwdata bits are junk on purpose; only the register width counts
   task set_filter(input logic en, input logic [COEF_BITS-1:0] a0, a1, a2, b1, b2);
      csr_write(REG_FILTER_ENABLE,  {31'($urandom), en});
      csr_write(REG_COEF_IN_NOW,    {8'($urandom), a0});
      csr_write(REG_COEF_IN_PREV,   {8'($urandom), a1});
      csr_write(REG_COEF_IN_OLDER,  {8'($urandom), a2});
      csr_write(REG_COEF_OUT_PREV,  {8'($urandom), b1});
      csr_write(REG_COEF_OUT_OLDER, {8'($urandom), b2});
      read_all_registers();
   endtask

   task random_coefficients(input bit stable);
      int b1, b2, lim;
      if (stable) begin
         // keep poles inside the unit circle with some margin
         b2  = int'($urandom_range(0, 6000000)) - 3000000;
         lim = COEF_ONE + b2 - 200000;
         b1  = int'($urandom_range(0, 2 * lim)) - lim;
      end else begin
         b1 = $urandom;
         b2 = $urandom;
      end
      set_filter(1'b1, COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                 COEF_BITS'(b1), COEF_BITS'(b2));
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficient set: steps between the rails and tiny values
      read_all_registers();
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(1);
      send_sample(-1);
      send_sample(0);
      send_sample(0);
      run_random(300);
      drain();

      // bypass: samples pass straight through, history frozen
      csr_write(REG_FILTER_ENABLE, {31'($urandom), 1'b0});
      csr_read(REG_FILTER_ENABLE);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(0);
      send_sample(-1);
      run_random(150);
      drain();

      // coefficient rails: unstable loop, saturates hard
      set_filter(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(0);
      run_random(150);
      drain();

      set_filter(1'b1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      run_random(150);
      drain();

      // writes to unmapped addresses must not disturb anything
      set_filter(1'b1, RESET_A0, RESET_A1, RESET_A2, RESET_B1, RESET_B2);
      csr_write(REG_UNUSED_A, $urandom);
      csr_write(REG_UNUSED_B, $urandom);
      read_all_registers();
      run_random(200);
      drain();

      random_coefficients(1'b1);
      run_random(180);
      drain();
      random_coefficients(1'b0);
      run_random(180);
      drain();
      random_coefficients(1'b1);
      run_random(180);
      drain();

      set_filter(1'b1, RESET_A0, RESET_A1, RESET_A2, RESET_B1, RESET_B2);
      run_random(200);
      drain();
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bqhp_pkg.sv
rtl/bqhp_csr.sv
rtl/bqhp_arith.sv
rtl/biquad_highpass_audio_filter.sv
rtl/bqhp_checker.sv
tb/tb_top.sv
